FILE: hdl/clock_counter_seven_seg_scan_core_defines.svh
// ----------------------------------------------------------------------------
// clock_counter_seven_seg_scan_core_defines
// assertion macros shared by the display clock core
// ----------------------------------------------------------------------------
`ifndef CLOCK_COUNTER_SEVEN_SEG_SCAN_CORE_DEFINES_SVH
`define CLOCK_COUNTER_SEVEN_SEG_SCAN_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define CCSS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define CCSS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/ccss_pkg.sv
// ----------------------------------------------------------------------------
// ccss_pkg
// types, constants and helpers of the seven-segment scan clock
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ccss_pkg;

   localparam int unsigned NUM_DIGITS  = 4;
   localparam int unsigned DIGIT_IDX_W = $clog2(NUM_DIGITS);

   localparam int unsigned TPS_W   = 16;
   localparam int unsigned COUNT_W = 7;
   localparam int unsigned BCD_W   = 4;
   localparam int unsigned SEG_W   = 8;

   localparam logic [TPS_W-1:0]   TPS_RESET       = 16'd100;
   localparam logic [COUNT_W-1:0] SEC_LIMIT_RESET = 7'd5;
   localparam logic [COUNT_W-1:0] MIN_LIMIT_RESET = 7'd3;
   localparam logic [COUNT_W-1:0] LIMIT_MAX       = 7'd99;

   // register map, word index
   typedef enum logic [1:0] {
      REG_TICKS_PER_SECOND = 2'd0,
      REG_SECONDS_LIMIT    = 2'd1,
      REG_MINUTES_LIMIT    = 2'd2
   } csr_index_type;

   // zero reads as one, above 99 saturates
   function automatic logic [COUNT_W-1:0] eff_limit(input logic [COUNT_W-1:0] v);
      logic [COUNT_W-1:0] r;
      if (v == '0) r = 7'd1;
      else if (v > LIMIT_MAX) r = LIMIT_MAX;
      else r = v;
      return r;
   endfunction

   // tens digit by reciprocal multiply, exact for 7-bit values
   function automatic logic [BCD_W-1:0] tens_of(input logic [COUNT_W-1:0] v);
      logic [14:0] p;
      p = 15'(v) * 15'd205;
      return p[14:11];
   endfunction

   function automatic logic [BCD_W-1:0] ones_of(input logic [COUNT_W-1:0] v);
      logic [COUNT_W-1:0] t;
      t = COUNT_W'(tens_of(v)) * 7'd10;
      return BCD_W'(v - t);
   endfunction

   // active-low segments, dp off, bit6 a down to bit0 g
   function automatic logic [SEG_W-1:0] seg_decode(input logic [BCD_W-1:0] d);
      logic [SEG_W-1:0] s;
      case (d)
         4'd0:    s = 8'h81;
         4'd1:    s = 8'hCF;
         4'd2:    s = 8'h92;
         4'd3:    s = 8'h86;
         4'd4:    s = 8'hCC;
         4'd5:    s = 8'hA4;
         4'd6:    s = 8'hA0;
         4'd7:    s = 8'h8F;
         4'd8:    s = 8'h80;
         4'd9:    s = 8'h84;
         default: s = 8'hFF;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/clock_counter_seven_seg_scan_core.sv
// ----------------------------------------------------------------------------
// clock_counter_seven_seg_scan_core
// minutes:seconds counter driving a four-digit multiplexed seven-segment display
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one beat per timer tick event. req_from_clock_timer = 1 is a
//   clock tick; 0 is a tick of another timer, accepted and dropped with no
//   rsp beat.
//   rsp channel: one beat per clock tick with the active-low segment pattern
//   of the scanned digit and its one-hot digit enable.
//   csr port: APB-style, ticks_per_second at 0x0, seconds_limit at 0x4,
//   minutes_limit at 0x8; pready is tied high, writes land in the access
//   cycle. Write only while the block is idle.
// Timing and throughput:
//   a clock tick shows on rsp the cycle after its req beat; one beat per cycle
//   unless rsp stalls, set by the single output register after the counter update.
// Reset:
//   counters, digits and scan index clear, limits return to 100 / 5 / 3.
// Stall:
//   while rsp holds a beat that is not taken, req_ready drops; it stays high
//   whenever the output register is empty or being drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "clock_counter_seven_seg_scan_core_defines.svh"

module clock_counter_seven_seg_scan_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // tick channel
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_from_clock_timer,
   // display channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [ccss_pkg::SEG_W-1:0]         rsp_segment_pattern,
   output logic [ccss_pkg::NUM_DIGITS-1:0]    rsp_digit_enable,
   // register port
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [3:0]                    csr_paddr,
   input  wire logic [31:0]                   csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);
   import ccss_pkg::*;

   // configuration
   logic [TPS_W-1:0]   tps_ff;
   logic [COUNT_W-1:0] sec_limit_ff;
   logic [COUNT_W-1:0] min_limit_ff;

   // counting state
   logic [TPS_W-1:0]       prescale_ff,  prescale_in;
   logic [COUNT_W-1:0]     seconds_ff,   seconds_in;
   logic [COUNT_W-1:0]     minutes_ff,   minutes_in;
   logic [BCD_W-1:0]       digits_ff [NUM_DIGITS];
   logic [BCD_W-1:0]       digits_in [NUM_DIGITS];
   logic [DIGIT_IDX_W-1:0] scan_ff,      scan_in;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SEG_W-1:0]       rsp_seg_ff,   rsp_seg_in;
   logic [NUM_DIGITS-1:0]  rsp_en_ff,    rsp_en_in;

   logic          req_accept;
   logic          tick;
   logic          csr_write;
   csr_index_type csr_index;

   logic [TPS_W:0]     prescale_sum;
   logic [TPS_W-1:0]   tps_eff;
   logic [COUNT_W-1:0] seconds_sum;
   logic [COUNT_W-1:0] minutes_sum;
   logic               second_wrap;
   logic               seconds_wrap;

   // handshake
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign tick       = req_accept && req_from_clock_timer;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_index_type'(csr_paddr[3:2]);

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff       <= TPS_RESET;
         sec_limit_ff <= SEC_LIMIT_RESET;
         min_limit_ff <= MIN_LIMIT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_TICKS_PER_SECOND: tps_ff       <= csr_pwdata[TPS_W-1:0];
            REG_SECONDS_LIMIT:    sec_limit_ff <= csr_pwdata[COUNT_W-1:0];
            REG_MINUTES_LIMIT:    min_limit_ff <= csr_pwdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // register reads
   always_comb begin
      unique case (csr_index)
         REG_TICKS_PER_SECOND: csr_prdata = 32'(tps_ff);
         REG_SECONDS_LIMIT:    csr_prdata = 32'(sec_limit_ff);
         REG_MINUTES_LIMIT:    csr_prdata = 32'(min_limit_ff);
         default:              csr_prdata = '0;
      endcase
   end

   // prescaler, scan index, seconds and minutes advance, digits latched on each second
   always_comb begin
      tps_eff      = (tps_ff == '0) ? TPS_W'(1) : tps_ff;
      prescale_sum = (TPS_W+1)'(prescale_ff) + (TPS_W+1)'(1);
      second_wrap  = prescale_sum >= (TPS_W+1)'(tps_eff);
      seconds_sum  = seconds_ff + COUNT_W'(1);
      seconds_wrap = seconds_sum >= eff_limit(sec_limit_ff);
      minutes_sum  = minutes_ff + COUNT_W'(1);

      prescale_in = prescale_ff;
      seconds_in  = seconds_ff;
      minutes_in  = minutes_ff;
      digits_in   = digits_ff;
      scan_in     = scan_ff;

      if (tick) begin
         scan_in = scan_ff + DIGIT_IDX_W'(1);
         if (second_wrap) begin
            prescale_in = '0;
            if (seconds_wrap) begin
               seconds_in = '0;
               minutes_in = (minutes_sum >= eff_limit(min_limit_ff)) ? '0 : minutes_sum;
            end else begin
               seconds_in = seconds_sum;
            end
            digits_in[0] = tens_of(minutes_in);
            digits_in[1] = ones_of(minutes_in);
            digits_in[2] = tens_of(seconds_in);
            digits_in[3] = ones_of(seconds_in);
         end else begin
            prescale_in = prescale_sum[TPS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff <= '0;
         seconds_ff  <= '0;
         minutes_ff  <= '0;
         scan_ff     <= '0;
         for (int i = 0; i < NUM_DIGITS; i++) digits_ff[i] <= '0;
      end else begin
         prescale_ff <= prescale_in;
         seconds_ff  <= seconds_in;
         minutes_ff  <= minutes_in;
         scan_ff     <= scan_in;
         digits_ff   <= digits_in;
      end
   end

   // output beat: pattern and enable of the newly scanned digit
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_seg_in   = rsp_seg_ff;
      rsp_en_in    = rsp_en_ff;
      if (tick) begin
         rsp_valid_in = 1'b1;
         rsp_seg_in   = seg_decode(digits_in[scan_in]);
         rsp_en_in    = NUM_DIGITS'(1) << scan_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_seg_ff <= rsp_seg_in;
      rsp_en_ff  <= rsp_en_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_segment_pattern = rsp_seg_ff;
   assign rsp_digit_enable    = rsp_en_ff;

   // checks
   `CCSS_ASSERT_NEXT(a_tick_gives_beat, clock, reset, tick, rsp_valid_ff, "clock tick lost its beat")
   `CCSS_ASSERT_NEXT(a_prescale_idle, clock, reset, !tick, $stable(prescale_ff), "prescaler moved without a tick")
   `CCSS_ASSERT_NOW(a_count_range, clock, reset, 1'b1, (seconds_ff < LIMIT_MAX) && (minutes_ff < LIMIT_MAX), "count beyond limit range")
   `CCSS_ASSERT_NOW(a_enable_onehot, clock, reset, rsp_valid_ff, $onehot(rsp_en_ff), "digit enable not one-hot")

endmodule

`default_nettype wire
